>>> src/inv9_pkg.sv
// Shared constants, types and pipeline latencies of the nine-point inverse transform lane.
`default_nettype none
package inv9_pkg;

	localparam int unsigned MODULUS_DEF = 3457;
	localparam int unsigned IN_W        = 16;
	localparam int unsigned OUT_W       = 12;
	localparam int unsigned CFG_W       = 12;
	localparam int unsigned CFG_AW      = 2;
	localparam int unsigned N_COEF      = 9;
	localparam int unsigned N_LANE      = 3;
	localparam int unsigned S_TDATA_W   = ((IN_W * N_COEF + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W   = ((OUT_W * N_COEF + 7) / 8) * 8;

	// Cycles through each pipelined unit.
	localparam int unsigned LAT_RED   = 2;
	localparam int unsigned LAT_BFLY  = LAT_RED + 3;
	localparam int unsigned LAT_TW    = LAT_RED + 2;
	localparam int unsigned LAT_TOTAL = LAT_RED + 2 * LAT_BFLY + LAT_TW + 1;

	typedef enum logic [CFG_AW-1:0] {
		REG_KAPPA   = 2'd0,
		REG_RHO     = 2'd1,
		REG_RHO_INV = 2'd2
	} cfg_reg_t;

	typedef logic signed [CFG_W-1:0] factor_t;

	typedef struct packed {
		factor_t kappa;
		factor_t rho;
		factor_t rho_inv;
	} cfg_t;

endpackage
`default_nettype wire

>>> src/inverse_ntt9_radix3_lane_unit.sv
// Throughput: one request per cycle while the result is not stalled; input reduction,
// row butterflies, untwist, column butterflies and the output register form one pipeline.
// A stalled result freezes the whole pipeline, so s_tready follows !m_tvalid || m_tready.
// Reset clears the valid pipeline and sets all three factor registers to zero.
`default_nettype none
module inverse_ntt9_radix3_lane_unit #(
	parameter int unsigned MODULUS = inv9_pkg::MODULUS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [inv9_pkg::CFG_AW-1:0]       cfg_addr,
	input  wire logic [inv9_pkg::CFG_W-1:0]        cfg_wdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// coef_in_0 .. coef_in_8, 16 bits each, from bit 0 up
	input  wire logic [inv9_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// coef_out_0 .. coef_out_8, 12 bits each, from bit 0 up, then zero padding
	output logic [inv9_pkg::M_TDATA_W-1:0]         m_tdata
);

	localparam int unsigned RW   = $clog2(MODULUS);
	localparam int unsigned HALF = (MODULUS - 1) / 2;
	localparam int unsigned LAT  = inv9_pkg::LAT_TOTAL;
	localparam int unsigned NC   = inv9_pkg::N_COEF;
	localparam int unsigned NL   = inv9_pkg::N_LANE;
	localparam int unsigned IW   = inv9_pkg::IN_W;
	localparam int unsigned OW   = inv9_pkg::OUT_W;
	localparam logic signed [RW-1:0] HALF_R = RW'(HALF);

	inv9_pkg::cfg_t   cfg_q;
	logic             en;
	logic [LAT-1:0]   vld_q;

	logic signed [RW-1:0] red_v [NC];
	logic signed [RW-1:0] row_v [NC];
	logic signed [RW-1:0] tw_v  [NC];
	logic signed [RW-1:0] col_a [NL];
	logic signed [RW-1:0] col_b [NL];
	logic signed [RW-1:0] col_c [NL];
	logic signed [RW-1:0] out_q [NC];

	inv9_pkg::factor_t tw_b [NL];
	inv9_pkg::factor_t tw_c [NL];

	logic [NC-1:0] red_ok;
	logic [NC-1:0] out_ok;

	// Factor registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				inv9_pkg::REG_KAPPA:   cfg_q.kappa   <= cfg_wdata;
				inv9_pkg::REG_RHO:     cfg_q.rho     <= cfg_wdata;
				inv9_pkg::REG_RHO_INV: cfg_q.rho_inv <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Input reduction, one unit per coefficient.
	for (genvar i = 0; i < NC; i++) begin : g_in
		inv9_red #(
			.MODULUS (MODULUS),
			.W       (IW)
		) u_red (
			.clk (clk),
			.en  (en),
			.x   ($signed(s_tdata[IW*i +: IW])),
			.r   (red_v[i])
		);
	end

	// Untwist factors: the first row triple passes unchanged.
	assign tw_b[0] = '0;
	assign tw_c[0] = '0;
	assign tw_b[1] = cfg_q.rho_inv;
	assign tw_c[1] = cfg_q.rho;
	assign tw_b[2] = cfg_q.rho;
	assign tw_c[2] = cfg_q.rho_inv;

	for (genvar g = 0; g < NL; g++) begin : g_row
		logic signed [RW-1:0] ra, rb, rc;

		inv9_bfly #(
			.MODULUS (MODULUS)
		) u_bfly (
			.clk   (clk),
			.en    (en),
			.kappa (cfg_q.kappa),
			.a     (red_v[3*g]),
			.b     (red_v[3*g+1]),
			.c     (red_v[3*g+2]),
			.a_out (ra),
			.b_out (rb),
			.c_out (rc)
		);

		assign row_v[3*g]   = ra;
		assign row_v[3*g+1] = rb;
		assign row_v[3*g+2] = rc;

		inv9_twist #(
			.MODULUS (MODULUS)
		) u_twist (
			.clk   (clk),
			.en    (en),
			.tw_b  (tw_b[g]),
			.tw_c  (tw_c[g]),
			.a     (row_v[3*g]),
			.b     (row_v[3*g+1]),
			.c     (row_v[3*g+2]),
			.a_out (tw_v[3*g]),
			.b_out (tw_v[3*g+1]),
			.c_out (tw_v[3*g+2])
		);
	end

	for (genvar g = 0; g < NL; g++) begin : g_col
		inv9_bfly #(
			.MODULUS (MODULUS)
		) u_bfly (
			.clk   (clk),
			.en    (en),
			.kappa (cfg_q.kappa),
			.a     (tw_v[g]),
			.b     (tw_v[g+3]),
			.c     (tw_v[g+6]),
			.a_out (col_a[g]),
			.b_out (col_b[g]),
			.c_out (col_c[g])
		);
	end

	// Merge the column lanes; the last column comes out rotated.
	always_ff @(posedge clk) begin
		if (en) begin
			out_q[0] <= col_a[0];
			out_q[3] <= col_b[0];
			out_q[6] <= col_c[0];
			out_q[1] <= col_a[1];
			out_q[4] <= col_b[1];
			out_q[7] <= col_c[1];
			out_q[8] <= col_a[2];
			out_q[2] <= col_b[2];
			out_q[5] <= col_c[2];
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_out
		assign m_tdata[OW*i +: OW] = OW'(out_q[i]);
		assign red_ok[i] = (red_v[i] >= -HALF_R) && (red_v[i] <= HALF_R);
		assign out_ok[i] = (out_q[i] >= -HALF_R) && (out_q[i] <= HALF_R);
	end
	assign m_tdata[inv9_pkg::M_TDATA_W-1:OW*NC] = '0;

`ifndef SYNTH
	a_red_centered: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[inv9_pkg::LAT_RED-1] |-> (&red_ok))
		else $error("input reduction left a residue outside the centered range");

	a_out_centered: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (&out_ok))
		else $error("result residue outside the centered range");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while the result was stalled");
`endif

endmodule
`default_nettype wire

>>> src/inv9_red.sv
// Two-stage reciprocal-multiply reduction of a signed word to a centered residue.
`default_nettype none
module inv9_red #(
	parameter int unsigned MODULUS = inv9_pkg::MODULUS_DEF,
	parameter int unsigned W       = inv9_pkg::IN_W
) (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic signed [W-1:0]                  x,
	output logic signed [$clog2(MODULUS)-1:0]         r
);

	localparam int unsigned RW   = $clog2(MODULUS);
	localparam int unsigned HALF = (MODULUS - 1) / 2;
	localparam logic signed [W:0]   RECIP  = (W+1)'((longint'(1) << W) / longint'(MODULUS));
	localparam logic signed [W+1:0] MOD_C  = (W+2)'(MODULUS);
	localparam logic signed [W+1:0] HALF_C = (W+2)'(HALF);

	logic signed [W-1:0]  x_s1;
	logic signed [2*W:0]  prod_s1;
	logic signed [W:0]    quot;
	logic signed [W+1:0]  rem0;
	logic signed [W+1:0]  rem_c;
	logic signed [RW-1:0] r_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x;
			prod_s1 <= x * RECIP;
		end
	end

	// The quotient estimate is off by at most one either way, so the
	// remainder lies in [-Q, 2Q) and one of four offsets centers it.
	always_comb begin
		quot = prod_s1[2*W:W];
		rem0 = (W+2)'(x_s1) - (W+2)'(quot * MOD_C);
		priority if (rem0 > HALF_C + MOD_C) begin
			rem_c = rem0 - MOD_C - MOD_C;
		end else if (rem0 > HALF_C) begin
			rem_c = rem0 - MOD_C;
		end else if (rem0 < -HALF_C) begin
			rem_c = rem0 + MOD_C;
		end else begin
			rem_c = rem0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2 <= RW'(rem_c);
		end
	end

	assign r = r_s2;

endmodule
`default_nettype wire

>>> src/inv9_bfly.sv
// One radix-3 inverse butterfly lane on centered residues.
`default_nettype none
module inv9_bfly #(
	parameter int unsigned MODULUS = inv9_pkg::MODULUS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire inv9_pkg::factor_t                   kappa,
	input  wire logic signed [$clog2(MODULUS)-1:0]   a,
	input  wire logic signed [$clog2(MODULUS)-1:0]   b,
	input  wire logic signed [$clog2(MODULUS)-1:0]   c,
	output logic signed [$clog2(MODULUS)-1:0]        a_out,
	output logic signed [$clog2(MODULUS)-1:0]        b_out,
	output logic signed [$clog2(MODULUS)-1:0]        c_out
);

	localparam int unsigned RW   = $clog2(MODULUS);
	localparam int unsigned PW   = inv9_pkg::CFG_W + RW;
	localparam int unsigned HALF = (MODULUS - 1) / 2;
	localparam logic signed [RW+1:0] MOD_X  = (RW+2)'(MODULUS);
	localparam logic signed [RW+1:0] HALF_X = (RW+2)'(HALF);

	// Centers a value that lies within one modulus of the centered range.
	function automatic logic signed [RW-1:0] fold(input logic signed [RW+1:0] v);
		logic signed [RW+1:0] w;
		if (v > HALF_X) begin
			w = v - MOD_X;
		end else if (v < -HALF_X) begin
			w = v + MOD_X;
		end else begin
			w = v;
		end
		return RW'(w);
	endfunction

	logic signed [RW-1:0] s_s1, d_s1, t_s1;
	logic signed [PW-1:0] prod_s2;
	logic signed [RW-1:0] u_s2, a_s2;
	logic signed [RW-1:0] u_q [inv9_pkg::LAT_RED];
	logic signed [RW-1:0] a_q [inv9_pkg::LAT_RED];
	logic signed [RW-1:0] p;
	logic signed [RW-1:0] a_s5, b_s5, c_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1 <= fold((RW+2)'(b) + (RW+2)'(c));
			d_s1 <= fold((RW+2)'(b) - (RW+2)'(c));
			t_s1 <= fold((RW+2)'(a) + (RW+2)'(a));
		end
	end

	// t + 2s stays within three half-moduli, so a single fold suffices.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= kappa * d_s1;
			u_s2    <= fold((RW+2)'(t_s1) - (RW+2)'(s_s1));
			a_s2    <= fold((RW+2)'(t_s1) + (RW+2)'(s_s1) + (RW+2)'(s_s1));
		end
	end

	inv9_red #(
		.MODULUS (MODULUS),
		.W       (PW)
	) u_red (
		.clk (clk),
		.en  (en),
		.x   (prod_s2),
		.r   (p)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			u_q[0] <= u_s2;
			a_q[0] <= a_s2;
			for (int i = 1; i < inv9_pkg::LAT_RED; i++) begin
				u_q[i] <= u_q[i-1];
				a_q[i] <= a_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5 <= a_q[inv9_pkg::LAT_RED-1];
			b_s5 <= fold((RW+2)'(u_q[inv9_pkg::LAT_RED-1]) + (RW+2)'(p));
			c_s5 <= fold((RW+2)'(u_q[inv9_pkg::LAT_RED-1]) - (RW+2)'(p));
		end
	end

	assign a_out = a_s5;
	assign b_out = b_s5;
	assign c_out = c_s5;

endmodule
`default_nettype wire

>>> src/inv9_twist.sv
// Untwist lane: multiplies the b and c residues of a row triple by their factors.
`default_nettype none
module inv9_twist #(
	parameter int unsigned MODULUS = inv9_pkg::MODULUS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire inv9_pkg::factor_t                   tw_b,
	input  wire inv9_pkg::factor_t                   tw_c,
	input  wire logic signed [$clog2(MODULUS)-1:0]   a,
	input  wire logic signed [$clog2(MODULUS)-1:0]   b,
	input  wire logic signed [$clog2(MODULUS)-1:0]   c,
	output logic signed [$clog2(MODULUS)-1:0]        a_out,
	output logic signed [$clog2(MODULUS)-1:0]        b_out,
	output logic signed [$clog2(MODULUS)-1:0]        c_out
);

	localparam int unsigned RW  = $clog2(MODULUS);
	localparam int unsigned PW  = inv9_pkg::CFG_W + RW;
	localparam int unsigned DLY = inv9_pkg::LAT_RED + 1;

	logic signed [PW-1:0] pb_s1, pc_s1;
	logic signed [RW-1:0] rb, rc;
	logic signed [RW-1:0] a_q [DLY];
	logic signed [RW-1:0] b_q [DLY];
	logic signed [RW-1:0] c_q [DLY];
	logic signed [RW-1:0] a_s4, b_s4, c_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pb_s1 <= tw_b * b;
			pc_s1 <= tw_c * c;
		end
	end

	inv9_red #(
		.MODULUS (MODULUS),
		.W       (PW)
	) u_red_b (
		.clk (clk),
		.en  (en),
		.x   (pb_s1),
		.r   (rb)
	);

	inv9_red #(
		.MODULUS (MODULUS),
		.W       (PW)
	) u_red_c (
		.clk (clk),
		.en  (en),
		.x   (pc_s1),
		.r   (rc)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			a_q[0] <= a;
			b_q[0] <= b;
			c_q[0] <= c;
			for (int i = 1; i < DLY; i++) begin
				a_q[i] <= a_q[i-1];
				b_q[i] <= b_q[i-1];
				c_q[i] <= c_q[i-1];
			end
		end
	end

	// A zero factor leaves the residue untouched instead of zeroing it.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s4 <= a_q[DLY-1];
			b_s4 <= (tw_b == '0) ? b_q[DLY-1] : rb;
			c_s4 <= (tw_c == '0) ? c_q[DLY-1] : rc;
		end
	end

	assign a_out = a_s4;
	assign b_out = b_s4;
	assign c_out = c_s4;

endmodule
`default_nettype wire
